// File: rtl/bofa_pkg.sv
// Package for the byte-oriented file ALU: opcodes, item and result records,
// architectural state record. No dependencies.
`default_nettype none

package bofa_pkg;

    typedef enum logic [4:0] {
        CMD_ADDWF  = 5'd0,
        CMD_ANDWF  = 5'd1,
        CMD_XORWF  = 5'd2,
        CMD_SUBWF  = 5'd3,
        CMD_CLRW   = 5'd4,
        CMD_RETURN = 5'd5,
        CMD_MOVWF  = 5'd6,
        CMD_CLRF   = 5'd7,
        CMD_COMF   = 5'd8,
        CMD_DECF   = 5'd9,
        CMD_INCF   = 5'd10,
        CMD_MOVF   = 5'd11,
        CMD_IORWF  = 5'd12,
        CMD_DECFSZ = 5'd13,
        CMD_INCFSZ = 5'd14,
        CMD_RLF    = 5'd15,
        CMD_RRF    = 5'd16,
        CMD_NOP    = 5'd17,
        CMD_SWAPF  = 5'd18,
        CMD_RETFIE = 5'd19
    } t_cmd;

    localparam int unsigned IN_DATA_W  = 24;
    localparam int unsigned OUT_DATA_W = 32;

    typedef struct packed {
        logic [4:0] cmd;
        logic [6:0] file_address;
        logic [1:0] bank;
        logic [7:0] file_value;
        logic       dest;
    } t_item;

    typedef struct packed {
        logic [7:0] w;
        logic       c;
        logic       dc;
        logic       z;
    } t_state;

    typedef struct packed {
        logic       write_file;
        logic [6:0] write_address;
        logic [1:0] write_bank;
        logic [7:0] file_result;
        logic [7:0] w_out;
        logic       carry_out;
        logic       digit_carry_out;
        logic       zero_out;
        logic       skip_next;
        logic       pop_return;
        logic       set_gie;
    } t_result;

endpackage

`default_nettype wire

// File: rtl/bofa_exec.sv
// Combinational execute of one byte-oriented instruction against W and flags.
// Depends on bofa_pkg.
`default_nettype none

module bofa_exec (
    input  var bofa_pkg::t_item   i_item,
    input  var bofa_pkg::t_state  i_state,
    output bofa_pkg::t_result     o_result,
    output bofa_pkg::t_state      o_state
);

    logic [7:0] f;
    logic [7:0] w;
    logic [8:0] sum9;
    logic [4:0] sum5;
    logic [7:0] r;
    logic       has_result;
    logic       force_file;
    logic       skip;
    logic       pop;
    logic       gie;
    bofa_pkg::t_state st;

    assign f    = i_item.file_value;
    assign w    = i_state.w;
    assign sum9 = {1'b0, f} + {1'b0, w};
    assign sum5 = {1'b0, f[3:0]} + {1'b0, w[3:0]};

    always_comb begin
        st         = i_state;
        r          = 8'h00;
        has_result = 1'b1;
        force_file = 1'b0;
        skip       = 1'b0;
        pop        = 1'b0;
        gie        = 1'b0;
        case (i_item.cmd)
            bofa_pkg::CMD_ADDWF: begin
                r    = sum9[7:0];
                st.c = sum9[8];
                st.dc = sum5[4];
                st.z = (sum9[7:0] == 8'h00);
            end
            bofa_pkg::CMD_ANDWF: begin
                r    = f & w;
                st.z = ((f & w) == 8'h00);
            end
            bofa_pkg::CMD_XORWF: begin
                r    = f ^ w;
                st.z = ((f ^ w) == 8'h00);
            end
            bofa_pkg::CMD_SUBWF: begin
                r     = f - w;
                st.c  = (f >= w);
                st.dc = (f[3:0] >= w[3:0]);
                st.z  = (f == w);
            end
            bofa_pkg::CMD_CLRW: begin
                has_result = 1'b0;
                st.w       = 8'h00;
                st.z       = 1'b1;
            end
            bofa_pkg::CMD_RETURN: begin
                has_result = 1'b0;
                pop        = 1'b1;
            end
            bofa_pkg::CMD_MOVWF: begin
                force_file = 1'b1;
                r          = w;
            end
            bofa_pkg::CMD_CLRF: begin
                force_file = 1'b1;
                r          = 8'h00;
                st.z       = 1'b1;
            end
            bofa_pkg::CMD_COMF: begin
                r    = ~f;
                st.z = (f == 8'hFF);
            end
            bofa_pkg::CMD_DECF: begin
                r    = f - 8'h01;
                st.z = (f == 8'h01);
            end
            bofa_pkg::CMD_INCF: begin
                r    = f + 8'h01;
                st.z = (f == 8'hFF);
            end
            bofa_pkg::CMD_MOVF: begin
                r    = f;
                st.z = (f == 8'h00);
            end
            bofa_pkg::CMD_IORWF: begin
                r    = f | w;
                st.z = ((f | w) == 8'h00);
            end
            bofa_pkg::CMD_DECFSZ: begin
                r    = f - 8'h01;
                skip = (f == 8'h01);
            end
            bofa_pkg::CMD_INCFSZ: begin
                r    = f + 8'h01;
                skip = (f == 8'hFF);
            end
            bofa_pkg::CMD_RLF: begin
                r    = {f[6:0], i_state.c};
                st.c = f[7];
            end
            bofa_pkg::CMD_RRF: begin
                r    = {i_state.c, f[7:1]};
                st.c = f[0];
            end
            bofa_pkg::CMD_SWAPF: begin
                r = {f[3:0], f[7:4]};
            end
            bofa_pkg::CMD_RETFIE: begin
                has_result = 1'b0;
                pop        = 1'b1;
                gie        = 1'b1;
            end
            default: begin
                has_result = 1'b0;
            end
        endcase

        o_result = '0;
        if (force_file || (has_result && i_item.dest)) begin
            o_result.write_file  = 1'b1;
            o_result.file_result = r;
        end else if (has_result) begin
            st.w = r;
        end
        o_result.write_address   = i_item.file_address;
        o_result.write_bank      = i_item.bank;
        o_result.w_out           = st.w;
        o_result.carry_out       = st.c;
        o_result.digit_carry_out = st.dc;
        o_result.zero_out        = st.z;
        o_result.skip_next       = skip;
        o_result.pop_return      = pop;
        o_result.set_gie         = gie;
        o_state                  = st;
    end

endmodule

`default_nettype wire

// File: rtl/bofa_state.sv
// Architectural state: working register W and the C, DC, Z flags.
// Depends on bofa_pkg.
`default_nettype none

module bofa_state (
    input  var logic              i_clk,
    input  var logic              i_rst_n,
    input  var logic              i_update,
    input  var bofa_pkg::t_state  i_next,
    output bofa_pkg::t_state      o_state
);

    bofa_pkg::t_state r_state;
    bofa_pkg::t_state n_state;

    always_comb begin
        n_state = i_update ? i_next : r_state;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_state = r_state;

endmodule

`default_nettype wire

// File: rtl/byte_oriented_file_alu_core.sv
// Top level of the byte-oriented file ALU: input register, execute, result register.
// Depends on bofa_pkg, bofa_exec, bofa_state.
//
//   channel  dir  width  contents
//   s_axis   in   24     instruction item
//   m_axis   out  32     write-back, new W, flags, skip and return marks
//
// The item is registered in the input register, then its result in the result register; one item
// per cycle sustained while the result is not stalled, as W and the flags loop through the execute logic.
// Synchronous active-low reset clears W, the flags and both valid bits.
// A stalled result holds the pipe; the input register still takes a transfer
// when it is empty or drains into the result register in the same cycle.
`default_nettype none

module byte_oriented_file_alu_core (
    input  var logic                               i_clk,
    input  var logic                               i_rst_n,
    input  var logic                               s_axis_tvalid,
    output logic                                   s_axis_tready,
    // [4:0] cmd, [11:5] file_address, [13:12] bank, [21:14] file_value,
    // [22] dest, [23] zero
    input  var logic [bofa_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  var logic                               m_axis_tready,
    // [0] write_file, [7:1] write_address, [9:8] write_bank,
    // [17:10] file_result, [25:18] w_out, [26] carry_out,
    // [27] digit_carry_out, [28] zero_out, [29] skip_next,
    // [30] pop_return, [31] set_gie
    output logic [bofa_pkg::OUT_DATA_W-1:0]        m_axis_tdata
);

    logic               r_in_valid;
    logic               n_in_valid;
    bofa_pkg::t_item    r_item;
    logic               r_out_valid;
    logic               n_out_valid;
    bofa_pkg::t_result  r_res;
    bofa_pkg::t_result  exec_res;
    bofa_pkg::t_state   cur_state;
    bofa_pkg::t_state   next_state;
    logic               advance;
    logic               in_xfer;

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    always_comb begin
        n_in_valid  = in_xfer ? 1'b1 : (advance ? 1'b0 : r_in_valid);
        n_out_valid = advance ? 1'b1 : ((r_out_valid && m_axis_tready) ? 1'b0 : r_out_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_item.cmd          <= s_axis_tdata[4:0];
            r_item.file_address <= s_axis_tdata[11:5];
            r_item.bank         <= s_axis_tdata[13:12];
            r_item.file_value   <= s_axis_tdata[21:14];
            r_item.dest         <= s_axis_tdata[22];
        end
        if (advance) begin
            r_res <= exec_res;
        end
    end

    bofa_exec u_exec (
        .i_item   (r_item),
        .i_state  (cur_state),
        .o_result (exec_res),
        .o_state  (next_state)
    );

    bofa_state u_state (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_update (advance),
        .i_next   (next_state),
        .o_state  (cur_state)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_res.set_gie, r_res.pop_return, r_res.skip_next,
                            r_res.zero_out, r_res.digit_carry_out, r_res.carry_out,
                            r_res.w_out, r_res.file_result, r_res.write_bank,
                            r_res.write_address, r_res.write_file};

endmodule

`default_nettype wire

// File: rtl/bofa_checker.sv
// Port-level checker for the byte-oriented file ALU, bound to the top level.
// Depends on bofa_pkg and byte_oriented_file_alu_core.
`default_nettype none

module bofa_checker (
    input  var logic                               i_clk,
    input  var logic                               i_rst_n,
    input  var logic                               s_axis_tvalid,
    input  var logic                               s_axis_tready,
    input  var logic [bofa_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    input  var logic                               m_axis_tvalid,
    input  var logic                               m_axis_tready,
    input  var logic [bofa_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);

    // result held while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // return and retfie never write the file
    a_pop_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[30]) |-> (!m_axis_tdata[0] && !m_axis_tdata[29]))
        else $error("return with file write or skip");

    a_gie_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[31]) |-> m_axis_tdata[30])
        else $error("gie set without return");

    a_no_write_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata[17:10] == 8'h00))
        else $error("file result nonzero without write");

endmodule

bind byte_oriented_file_alu_core bofa_checker u_bofa_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// File: tb/tb_byte_oriented_file_alu_core.sv
// Self-checking bench for byte_oriented_file_alu_core: directed table of instructions,
// then random instruction streams checked against a cycle-free model of W and C/DC/Z.
// Depends on bofa_pkg and the core RTL.
module tb_byte_oriented_file_alu_core;

    localparam int DIR_ROWS        = 25;
    localparam int ITEMS_PER_PHASE = 225;
    localparam int NUM_PHASES      = 4;
    localparam int STALL_LIMIT     = 1000;
    localparam int SQUEEZE_CYCLES  = 64;
    localparam int TAIL_CYCLES     = 8;
    localparam int MAX_PRINTS      = 40;
    localparam logic [4:0] CMD_UNUSED_LO = 5'd20;
    localparam logic [4:0] CMD_UNUSED_HI = 5'd31;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // [4:0] cmd, [11:5] file_address, [13:12] bank, [21:14] file_value, [22] dest, [23] zero
    logic [23:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [0] write_file, [7:1] write_address, [9:8] write_bank, [17:10] file_result,
    // [25:18] w_out, [26] carry_out, [27] digit_carry_out, [28] zero_out,
    // [29] skip_next, [30] pop_return, [31] set_gie
    logic [31:0] m_axis_tdata;

    byte_oriented_file_alu_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // architectural state of the model
    logic [7:0] alu_w  = '0;
    logic       alu_c  = 1'b0;
    logic       alu_dc = 1'b0;
    logic       alu_z  = 1'b0;

    bofa_pkg::t_result due_results[$];
    int unsigned src_idle_pct  = 0;
    int unsigned sink_stall_pct = 0;
    bit          squeeze_armed = 1'b0;
    bit          squeeze_done  = 1'b0;
    int          hold_left     = 0;
    int          mismatches    = 0;
    int          checked       = 0;
    int          instr_sent    = 0;
    int          backpressured = 0;
    bit [31:0]   cmds_seen     = '0;

    bofa_pkg::t_item   dir_items[DIR_ROWS];
    bit                dir_typed[DIR_ROWS];
    bofa_pkg::t_result dir_want[DIR_ROWS];

    function automatic bofa_pkg::t_item mk_item(logic [4:0] cmd, logic [6:0] addr,
                                                logic [1:0] bnk, logic [7:0] fv, logic dst);
        bofa_pkg::t_item it;
        it.cmd          = cmd;
        it.file_address = addr;
        it.bank         = bnk;
        it.file_value   = fv;
        it.dest         = dst;
        return it;
    endfunction

    // executes one instruction on the model state, returns the expected transfer
    function automatic bofa_pkg::t_result execute_instr(bofa_pkg::t_item it);
        bofa_pkg::t_result res;
        logic [8:0] sum;
        logic [7:0] f;
        logic [7:0] w;
        logic [7:0] r;
        logic       has_result;
        logic       force_file;
        f          = it.file_value;
        w          = alu_w;
        r          = '0;
        has_result = 1'b1;
        force_file = 1'b0;
        res        = '0;
        case (it.cmd)
            bofa_pkg::CMD_ADDWF: begin
                sum    = {1'b0, f} + {1'b0, w};
                r      = sum[7:0];
                alu_c  = sum[8];
                alu_dc = ({1'b0, f[3:0]} + {1'b0, w[3:0]}) > 5'h0F;
                alu_z  = (r == 8'h00);
            end
            bofa_pkg::CMD_ANDWF: begin r = f & w; alu_z = (r == 8'h00); end
            bofa_pkg::CMD_XORWF: begin r = f ^ w; alu_z = (r == 8'h00); end
            bofa_pkg::CMD_SUBWF: begin
                r      = f - w;
                alu_c  = (f >= w);
                alu_dc = (f[3:0] >= w[3:0]);
                alu_z  = (r == 8'h00);
            end
            bofa_pkg::CMD_CLRW: begin has_result = 1'b0; w = 8'h00; alu_z = 1'b1; end
            bofa_pkg::CMD_RETURN: begin has_result = 1'b0; res.pop_return = 1'b1; end
            bofa_pkg::CMD_MOVWF: begin force_file = 1'b1; r = w; end
            bofa_pkg::CMD_CLRF: begin force_file = 1'b1; r = 8'h00; alu_z = 1'b1; end
            bofa_pkg::CMD_COMF: begin r = ~f; alu_z = (r == 8'h00); end
            bofa_pkg::CMD_DECF: begin r = f - 8'h01; alu_z = (r == 8'h00); end
            bofa_pkg::CMD_INCF: begin r = f + 8'h01; alu_z = (r == 8'h00); end
            bofa_pkg::CMD_MOVF: begin r = f; alu_z = (r == 8'h00); end
            bofa_pkg::CMD_IORWF: begin r = f | w; alu_z = (r == 8'h00); end
            bofa_pkg::CMD_DECFSZ: begin r = f - 8'h01; res.skip_next = (r == 8'h00); end
            bofa_pkg::CMD_INCFSZ: begin r = f + 8'h01; res.skip_next = (r == 8'h00); end
            bofa_pkg::CMD_RLF: begin r = {f[6:0], alu_c}; alu_c = f[7]; end
            bofa_pkg::CMD_RRF: begin r = {alu_c, f[7:1]}; alu_c = f[0]; end
            bofa_pkg::CMD_SWAPF: r = {f[3:0], f[7:4]};
            bofa_pkg::CMD_RETFIE: begin
                has_result     = 1'b0;
                res.pop_return = 1'b1;
                res.set_gie    = 1'b1;
            end
            default: has_result = 1'b0;
        endcase
        if (force_file || (has_result && it.dest)) begin
            res.write_file  = 1'b1;
            res.file_result = r;
        end else if (has_result) begin
            w = r;
        end
        alu_w               = w;
        res.write_address   = it.file_address;
        res.write_bank      = it.bank;
        res.w_out           = alu_w;
        res.carry_out       = alu_c;
        res.digit_carry_out = alu_dc;
        res.zero_out        = alu_z;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        if (mismatches < MAX_PRINTS)
            $display("MISMATCH at %0t, result %0d, %s: got 0x%0h, expected 0x%0h",
                     $realtime, checked, what, got, want);
        mismatches++;
    endtask

    task automatic offer(input bofa_pkg::t_item it, input bit typed,
                         input bofa_pkg::t_result typed_want);
        bofa_pkg::t_result want;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, it.dest, it.file_value, it.bank, it.file_address, it.cmd};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        want = execute_instr(it);
        due_results.push_back(typed ? typed_want : want);
        cmds_seen[it.cmd] = 1'b1;
        instr_sent++;
    endtask

    function automatic logic [7:0] corner_value();
        case ($urandom_range(0, 6))
            0: return 8'h00;
            1: return 8'h01;
            2: return 8'h7F;
            3: return 8'h80;
            4: return 8'h0F;
            5: return 8'hF0;
            default: return 8'hFF;
        endcase
    endfunction

    function automatic bofa_pkg::t_item random_item();
        logic [4:0] cmd;
        logic [7:0] fv;
        if ($urandom_range(0, 9) == 0)
            cmd = 5'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
        else
            cmd = 5'($urandom_range(bofa_pkg::CMD_ADDWF, bofa_pkg::CMD_RETFIE));
        fv = ($urandom_range(0, 3) == 0) ? corner_value() : 8'($urandom_range(0, 255));
        return mk_item(cmd, 7'($urandom_range(0, 127)), 2'($urandom_range(0, 3)), fv,
                       1'($urandom_range(0, 1)));
    endfunction

    // receiver: random stalls, plus one long hold-off to fill the pipe
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end else if (squeeze_armed && !squeeze_done) begin
            m_axis_tready <= 1'b0;
            hold_left     <= SQUEEZE_CYCLES;
            squeeze_done  <= 1'b1;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        bofa_pkg::t_result got;
        bofa_pkg::t_result want;
        if (i_rst_n && s_axis_tvalid && !s_axis_tready && hold_left != 0)
            backpressured++;
        if (i_rst_n && m_axis_tvalid === 1'b1 && m_axis_tready) begin
            got.write_file      = m_axis_tdata[0];
            got.write_address   = m_axis_tdata[7:1];
            got.write_bank      = m_axis_tdata[9:8];
            got.file_result     = m_axis_tdata[17:10];
            got.w_out           = m_axis_tdata[25:18];
            got.carry_out       = m_axis_tdata[26];
            got.digit_carry_out = m_axis_tdata[27];
            got.zero_out        = m_axis_tdata[28];
            got.skip_next       = m_axis_tdata[29];
            got.pop_return      = m_axis_tdata[30];
            got.set_gie         = m_axis_tdata[31];
            if (due_results.size() == 0) begin
                report_mismatch("unexpected transfer", m_axis_tdata[7:0], 8'h00);
            end else begin
                want = due_results.pop_front();
                if (got.write_file !== want.write_file)
                    report_mismatch("write_file", 8'(got.write_file), 8'(want.write_file));
                if (got.write_address !== want.write_address)
                    report_mismatch("write_address", 8'(got.write_address),
                                    8'(want.write_address));
                if (got.write_bank !== want.write_bank)
                    report_mismatch("write_bank", 8'(got.write_bank), 8'(want.write_bank));
                if (got.file_result !== want.file_result)
                    report_mismatch("file_result", got.file_result, want.file_result);
                if (got.w_out !== want.w_out)
                    report_mismatch("w_out", got.w_out, want.w_out);
                if (got.carry_out !== want.carry_out)
                    report_mismatch("carry_out", 8'(got.carry_out), 8'(want.carry_out));
                if (got.digit_carry_out !== want.digit_carry_out)
                    report_mismatch("digit_carry_out", 8'(got.digit_carry_out),
                                    8'(want.digit_carry_out));
                if (got.zero_out !== want.zero_out)
                    report_mismatch("zero_out", 8'(got.zero_out), 8'(want.zero_out));
                if (got.skip_next !== want.skip_next)
                    report_mismatch("skip_next", 8'(got.skip_next), 8'(want.skip_next));
                if (got.pop_return !== want.pop_return)
                    report_mismatch("pop_return", 8'(got.pop_return), 8'(want.pop_return));
                if (got.set_gie !== want.set_gie)
                    report_mismatch("set_gie", 8'(got.set_gie), 8'(want.set_gie));
            end
            checked++;
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Watchdog: no transfer for %0d cycles, %0d results outstanding",
                 STALL_LIMIT, due_results.size());
        $display("TEST FAILED");
        $finish;
    end

    initial begin : stimulus
        int unsigned src_pct[NUM_PHASES];
        int unsigned sink_pct[NUM_PHASES];
        src_pct  = '{0, 87, 0, 11};
        sink_pct = '{0, 0, 87, 11};

        dir_typed = '{default: 1'b0};
        dir_want  = '{default: '0};
        // right after reset: W and flags are zero
        dir_items[0]  = mk_item(bofa_pkg::CMD_MOVWF, 7'h7F, 2'd3, 8'hFF, 1'b0);
        dir_typed[0]  = 1'b1;
        dir_want[0]   = '{1'b1, 7'h7F, 2'd3, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};
        dir_items[1]  = mk_item(bofa_pkg::CMD_MOVF, 7'h00, 2'd0, 8'h00, 1'b0);
        dir_typed[1]  = 1'b1;
        dir_want[1]   = '{1'b0, 7'h00, 2'd0, 8'h00, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0};
        dir_items[2]  = mk_item(bofa_pkg::CMD_ADDWF, 7'h01, 2'd1, 8'hFF, 1'b0);
        // wraps to zero
        dir_items[3]  = mk_item(bofa_pkg::CMD_ADDWF, 7'h02, 2'd2, 8'h01, 1'b0);
        // f == W
        dir_items[4]  = mk_item(bofa_pkg::CMD_SUBWF, 7'h03, 2'd3, 8'h00, 1'b1);
        dir_items[5]  = mk_item(bofa_pkg::CMD_MOVF, 7'h04, 2'd0, 8'h80, 1'b0);
        // borrow
        dir_items[6]  = mk_item(bofa_pkg::CMD_SUBWF, 7'h05, 2'd1, 8'h7F, 1'b1);
        dir_items[7]  = mk_item(bofa_pkg::CMD_ANDWF, 7'h06, 2'd2, 8'h7F, 1'b0);
        dir_items[8]  = mk_item(bofa_pkg::CMD_XORWF, 7'h07, 2'd3, 8'hAA, 1'b0);
        dir_items[9]  = mk_item(bofa_pkg::CMD_IORWF, 7'h08, 2'd0, 8'h55, 1'b1);
        dir_items[10] = mk_item(bofa_pkg::CMD_COMF, 7'h09, 2'd1, 8'hFF, 1'b1);
        dir_items[11] = mk_item(bofa_pkg::CMD_DECF, 7'h0A, 2'd2, 8'h00, 1'b1);
        dir_items[12] = mk_item(bofa_pkg::CMD_INCF, 7'h0B, 2'd3, 8'hFF, 1'b1);
        // skips
        dir_items[13] = mk_item(bofa_pkg::CMD_DECFSZ, 7'h0C, 2'd0, 8'h01, 1'b1);
        // skips, W gets 0
        dir_items[14] = mk_item(bofa_pkg::CMD_INCFSZ, 7'h0D, 2'd1, 8'hFF, 1'b0);
        dir_items[15] = mk_item(bofa_pkg::CMD_RLF, 7'h0E, 2'd2, 8'h80, 1'b1);
        dir_items[16] = mk_item(bofa_pkg::CMD_RRF, 7'h0F, 2'd3, 8'h01, 1'b1);
        dir_items[17] = mk_item(bofa_pkg::CMD_SWAPF, 7'h10, 2'd0, 8'hA5, 1'b0);
        // file write anyway
        dir_items[18] = mk_item(bofa_pkg::CMD_CLRF, 7'h11, 2'd1, 8'hFF, 1'b0);
        // no file write
        dir_items[19] = mk_item(bofa_pkg::CMD_CLRW, 7'h12, 2'd2, 8'hFF, 1'b1);
        dir_items[20] = mk_item(bofa_pkg::CMD_RETURN, 7'h55, 2'd1, 8'h5A, 1'b1);
        dir_items[21] = mk_item(bofa_pkg::CMD_RETFIE, 7'h2A, 2'd2, 8'hA5, 1'b1);
        dir_items[22] = mk_item(bofa_pkg::CMD_NOP, 7'h7F, 2'd3, 8'hFF, 1'b1);
        dir_items[23] = mk_item(CMD_UNUSED_LO, 7'h00, 2'd0, 8'h00, 1'b1);
        dir_items[24] = mk_item(CMD_UNUSED_HI, 7'h7F, 2'd3, 8'hFF, 1'b1);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < DIR_ROWS; i++)
            offer(dir_items[i], dir_typed[i], dir_want[i]);

        for (int p = 0; p < NUM_PHASES; p++) begin
            src_idle_pct   = src_pct[p];
            sink_stall_pct = sink_pct[p];
            if (p == 0)
                squeeze_armed = 1'b1;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                offer(random_item(), 1'b0, '0);
        end
        s_axis_tvalid <= 1'b0;
        sink_stall_pct = 0;

        while (due_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d instructions (%0d directed), %0d opcode codes of 32 seen;",
                 instr_sent, DIR_ROWS, $countones(cmds_seen));
        $display("checked %0d results, input held off %0d cycles, %0d mismatches.",
                 checked, backpressured, mismatches);
        if (mismatches == 0 && due_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
